@@ hdl/alfe_pkg.sv @@
`default_nettype none

package alfe_pkg;

    // Frame geometry
    localparam int MAX_LEDS     = 256;
    localparam int BITS_PER_LED = 24;
    localparam int RESET_SLOTS  = 40;

    localparam int ADDR_W  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 8;
    localparam int POS_W   = 13;
    localparam int LEDC_W  = 9;
    localparam int BIT_W   = 5;
    localparam int PERIOD_W = 16;
    localparam int CFG_DATA_W = 16;

    // Brightness product c*b fits 15 bits (255*100)
    localparam int PROD_W  = 15;

    // floor(x/100) = (x*RECIP100) >> SHIFT100, exact for x < 43699
    localparam int RECIP100_W = 13;
    localparam logic [RECIP100_W-1:0] RECIP100 = 13'd5243;
    localparam int SHIFT100 = 19;

    // floor(x/3) = (x*RECIP3) >> SHIFT3, exact for x < 2^19
    localparam int DIV3_IN_W = 18;
    localparam int RECIP3_W  = 18;
    localparam logic [RECIP3_W-1:0] RECIP3 = 18'd174763;
    localparam int SHIFT3 = 19;

    localparam logic [7:0] BRIGHT_MAX = 8'd100;

    // Request codes
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_SLOT  = 2'd2;

    // Register indexes
    localparam logic CFG_TIMER_PERIOD = 1'b0;
    localparam logic CFG_LED_COUNT    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_READ
    } state_t;

endpackage

`default_nettype wire

@@ hdl/alfe_ram.sv @@
`default_nettype none

module alfe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/alfe_scale.sv @@
`default_nettype none

// Two-step brightness scaling: c*b registered, then /100 by reciprocal.
module alfe_scale (
    input  wire logic                            clk,
    input  wire logic                            load,
    input  wire logic [alfe_pkg::CHAN_W-1:0]     green,
    input  wire logic [alfe_pkg::CHAN_W-1:0]     red,
    input  wire logic [alfe_pkg::CHAN_W-1:0]     blue,
    input  wire logic [alfe_pkg::CHAN_W-1:0]     brightness,
    input  wire logic [alfe_pkg::ADDR_W-1:0]     index_in,
    output logic      [alfe_pkg::ADDR_W-1:0]     index_out,
    output logic      [alfe_pkg::COLOR_W-1:0]    color
);

    localparam int QW = alfe_pkg::PROD_W + alfe_pkg::RECIP100_W;
    localparam int PROD_W = alfe_pkg::PROD_W;

    logic [6:0]                      bright_clamped;
    logic [alfe_pkg::PROD_W-1:0]     prod_g_next, prod_r_next, prod_b_next;
    logic [alfe_pkg::PROD_W-1:0]     prod_g_reg, prod_r_reg, prod_b_reg;
    logic [alfe_pkg::ADDR_W-1:0]     index_reg;
    logic [QW-1:0]                   q_g, q_r, q_b;

    assign bright_clamped = (brightness > alfe_pkg::BRIGHT_MAX) ?
                            alfe_pkg::BRIGHT_MAX[6:0] : brightness[6:0];

    assign prod_g_next = PROD_W'(green) * PROD_W'(bright_clamped);
    assign prod_r_next = PROD_W'(red)   * PROD_W'(bright_clamped);
    assign prod_b_next = PROD_W'(blue)  * PROD_W'(bright_clamped);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_g_reg <= prod_g_next;
            prod_r_reg <= prod_r_next;
            prod_b_reg <= prod_b_next;
            index_reg  <= index_in;
        end
    end

    assign q_g = QW'(prod_g_reg) * QW'(alfe_pkg::RECIP100);
    assign q_r = QW'(prod_r_reg) * QW'(alfe_pkg::RECIP100);
    assign q_b = QW'(prod_b_reg) * QW'(alfe_pkg::RECIP100);

    assign color = {q_g[alfe_pkg::SHIFT100 +: alfe_pkg::CHAN_W],
                    q_r[alfe_pkg::SHIFT100 +: alfe_pkg::CHAN_W],
                    q_b[alfe_pkg::SHIFT100 +: alfe_pkg::CHAN_W]};
    assign index_out = index_reg;

endmodule

`default_nettype wire

@@ hdl/addressable_led_frame_encoder_unit.sv @@
`default_nettype none

// Channel    | Direction | Handshake           | Payload
// -----------+-----------+---------------------+-------------------------------------------
// input      | in        | in_valid / in_stall | req_type, led_number, green, red, blue,
//            |           |                     | brightness
// result     | out       | out_valid/out_stall | compare_value, last_slot
// config     | in        | cfg_we              | cfg_index, cfg_data
//
// Sequencing: a colour write is accepted with the c*b product registered,
// then holds the input while the divide-by-100 and store write happen; a
// slot request of an active frame is accepted with the store read, then
// the bit select and /3 multiply load the output register. Start, idle
// slot and unused codes are taken in the idle state alone.
// The sequence follows from the store's registered read and the two-stage
// scaling multiply.
// Reset: asynchronous, active low; clears control and the per-LED valid bits,
// so every colour reads as zero until written, and sets period 89, one LED.
// Stalls: the output register lets a new transaction be accepted while a
// result waits; a slot result waits in the read state only when the output
// register is full and stalled.
module addressable_led_frame_encoder_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // config
    input  wire logic                                cfg_we,
    input  wire logic                                cfg_index,
    input  wire logic [alfe_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input channel
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [1:0]                          req_type,
    input  wire logic [7:0]                          led_number,
    input  wire logic [7:0]                          green,
    input  wire logic [7:0]                          red,
    input  wire logic [7:0]                          blue,
    input  wire logic [7:0]                          brightness,
    // result channel
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [15:0]                              compare_value,
    output logic                                     last_slot
);

    localparam int CW = alfe_pkg::POS_W + 1;   // frame length arithmetic
    localparam int MW = alfe_pkg::DIV3_IN_W + alfe_pkg::RECIP3_W;

    // ---------------- configuration registers ----------------
    logic [alfe_pkg::PERIOD_W-1:0] timer_period_reg;
    logic [7:0]                    led_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_period_reg <= 16'd89;
            led_count_reg    <= 8'd1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == alfe_pkg::CFG_TIMER_PERIOD)
            begin
                timer_period_reg <= cfg_data;
            end
            else
            begin
                led_count_reg <= cfg_data[7:0];
            end
        end
    end

    // Effective LED count: zero as one, limited to the store depth
    logic [alfe_pkg::LEDC_W-1:0] n_raw, n_eff;
    assign n_raw = (led_count_reg == 8'd0) ? alfe_pkg::LEDC_W'(1)
                                           : alfe_pkg::LEDC_W'(led_count_reg);
    assign n_eff = (n_raw > alfe_pkg::LEDC_W'(alfe_pkg::MAX_LEDS)) ?
                   alfe_pkg::LEDC_W'(alfe_pkg::MAX_LEDS) : n_raw;

    // ---------------- control state ----------------
    alfe_pkg::state_t state_reg, state_next;

    logic                          frame_active_reg, frame_active_next;
    logic [alfe_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [alfe_pkg::LEDC_W-1:0]   led_reg, led_next;     // pos / 24
    logic [alfe_pkg::BIT_W-1:0]    bit_reg, bit_next;     // 23 - pos % 24

    logic                          is_data_reg, last_q_reg, valid_q_reg;
    logic [alfe_pkg::BIT_W-1:0]    bit_sel_reg;

    logic                          out_valid_reg, out_valid_next;
    logic [15:0]                   compare_reg;
    logic                          last_reg;

    logic [alfe_pkg::MAX_LEDS-1:0] valid_reg;

    logic accept, slot_go, out_free, load_out, scale_load, ram_we;

    assign accept   = in_valid && !in_stall;
    assign slot_go  = (req_type == alfe_pkg::REQ_SLOT) && frame_active_reg;
    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            alfe_pkg::ST_IDLE:
            begin
                if (accept && req_type == alfe_pkg::REQ_WRITE)
                begin
                    state_next = alfe_pkg::ST_SCALE;
                end
                else if (accept && slot_go)
                begin
                    state_next = alfe_pkg::ST_READ;
                end
            end
            alfe_pkg::ST_SCALE:
            begin
                state_next = alfe_pkg::ST_IDLE;
            end
            alfe_pkg::ST_READ:
            begin
                if (out_free)
                begin
                    state_next = alfe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = alfe_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall   = 1'b1;
        ram_we     = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            alfe_pkg::ST_IDLE:  in_stall = 1'b0;
            alfe_pkg::ST_SCALE: ram_we   = 1'b1;
            alfe_pkg::ST_READ:  load_out = out_free;
            default:            in_stall = 1'b1;
        endcase
    end

    assign scale_load = accept && (req_type == alfe_pkg::REQ_WRITE);

    // ---------------- colour write path ----------------
    logic [7:0]                      led_clamped, wr_index8;
    logic [alfe_pkg::ADDR_W-1:0]     scale_index;
    logic [alfe_pkg::COLOR_W-1:0]    scale_color;

    always_comb
    begin
        led_clamped = (led_number == 8'd0) ? 8'd1 : led_number;
        if (alfe_pkg::LEDC_W'(led_clamped) > n_eff)
        begin
            led_clamped = n_eff[7:0];
        end
        wr_index8 = led_clamped - 8'd1;
    end

    alfe_scale u_scale (
        .clk        (clk),
        .load       (scale_load),
        .green      (green),
        .red        (red),
        .blue       (blue),
        .brightness (brightness),
        .index_in   (wr_index8[alfe_pkg::ADDR_W-1:0]),
        .index_out  (scale_index),
        .color      (scale_color)
    );

    // ---------------- colour store ----------------
    logic [alfe_pkg::COLOR_W-1:0] ram_rdata;
    logic                         ram_re;

    assign ram_re = accept && slot_go;

    alfe_ram #(
        .WIDTH (alfe_pkg::COLOR_W),
        .DEPTH (alfe_pkg::MAX_LEDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (scale_index),
        .wdata (scale_color),
        .re    (ram_re),
        .raddr (led_reg[alfe_pkg::ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Valid bits stand in for the zero fill at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ram_we)
        begin
            valid_reg[scale_index] <= 1'b1;
        end
    end

    // ---------------- frame sequencing ----------------
    logic [CW-1:0] data_slots, total_slots, pos_inc;
    logic          is_data, is_last;

    assign data_slots  = CW'(n_eff) * CW'(alfe_pkg::BITS_PER_LED);
    assign total_slots = data_slots + CW'(alfe_pkg::RESET_SLOTS);
    assign pos_inc     = CW'(pos_reg) + CW'(1);
    assign is_data     = CW'(pos_reg) < data_slots;
    assign is_last     = pos_inc >= total_slots;

    always_comb
    begin
        frame_active_next = frame_active_reg;
        pos_next          = pos_reg;
        led_next          = led_reg;
        bit_next          = bit_reg;
        if (accept && req_type == alfe_pkg::REQ_START)
        begin
            frame_active_next = 1'b1;
            pos_next          = '0;
            led_next          = '0;
            bit_next          = alfe_pkg::BIT_W'(alfe_pkg::BITS_PER_LED - 1);
        end
        else if (accept && slot_go)
        begin
            if (is_last)
            begin
                frame_active_next = 1'b0;
                pos_next          = '0;
                led_next          = '0;
                bit_next          = alfe_pkg::BIT_W'(alfe_pkg::BITS_PER_LED - 1);
            end
            else
            begin
                pos_next = pos_inc[alfe_pkg::POS_W-1:0];
                if (bit_reg == '0)
                begin
                    bit_next = alfe_pkg::BIT_W'(alfe_pkg::BITS_PER_LED - 1);
                    led_next = led_reg + alfe_pkg::LEDC_W'(1);
                end
                else
                begin
                    bit_next = bit_reg - alfe_pkg::BIT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= alfe_pkg::ST_IDLE;
            frame_active_reg <= 1'b0;
            pos_reg          <= '0;
            led_reg          <= '0;
            bit_reg          <= alfe_pkg::BIT_W'(alfe_pkg::BITS_PER_LED - 1);
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            frame_active_reg <= frame_active_next;
            pos_reg          <= pos_next;
            led_reg          <= led_next;
            bit_reg          <= bit_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Slot context travelling with the store read
    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            is_data_reg <= is_data;
            last_q_reg  <= is_last;
            bit_sel_reg <= bit_reg;
            valid_q_reg <= valid_reg[led_reg[alfe_pkg::ADDR_W-1:0]];
        end
    end

    // ---------------- compare value ----------------
    logic [alfe_pkg::COLOR_W-1:0]   word;
    logic [alfe_pkg::PERIOD_W:0]    p1;
    logic [alfe_pkg::DIV3_IN_W-1:0] div_in;
    logic [MW-1:0]                  div_prod;
    logic [15:0]                    cmp;

    assign word     = valid_q_reg ? ram_rdata : '0;
    assign p1       = (alfe_pkg::PERIOD_W + 1)'(timer_period_reg) + 17'd1;
    // one bit: 2*(period+1)/3, zero bit: (period+1)/3
    assign div_in   = word[bit_sel_reg] ? {1'b0, p1} << 1 : {1'b0, p1};
    assign div_prod = MW'(div_in) * MW'(alfe_pkg::RECIP3);
    assign cmp      = is_data_reg ? div_prod[alfe_pkg::SHIFT3 +: 16] : 16'd0;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            compare_reg <= cmp;
            last_reg    <= last_q_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign compare_value = compare_reg;
    assign last_slot     = last_reg;

    // ---------------- assertions ----------------
    a_idle_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !frame_active_reg |-> (pos_reg == '0))
        else $error("slot position not cleared while idle");

    a_scale_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == alfe_pkg::ST_SCALE) |=> (state_reg == alfe_pkg::ST_IDLE))
        else $error("scale stage held longer than one cycle");

    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == alfe_pkg::ST_READ && last_q_reg) |-> !frame_active_reg)
        else $error("last slot pending while frame still active");

    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_reg < alfe_pkg::BIT_W'(alfe_pkg::BITS_PER_LED))
        else $error("bit counter out of range");

endmodule

`default_nettype wire

@@ test/tb_addressable_led_frame_encoder_unit.sv @@
`default_nettype none

// Testbench for the addressable LED frame encoder.
// The driver offers request transactions from request_queue. The encoder
// model below tracks the colour store, the frame position and the two
// registers, and queues the slot results that it expects. The monitor
// checks every result transaction against the oldest one still waiting.
module tb_addressable_led_frame_encoder_unit;

    // Code 3 is not decoded by the block and must be ignored
    localparam logic [1:0] REQ_SPARE = 2'd3;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 6;     // lets a trailing colour write finish; allow a margin
    localparam int LONG_HOLD     = 300;   // output hold-off, long enough to back up the input

    typedef struct {
        logic [1:0] kind;
        logic [7:0] led;
        logic [7:0] g;
        logic [7:0] r;
        logic [7:0] b;
        logic [7:0] bright;
    } led_req_t;

    typedef struct {
        logic [15:0] compare;
        logic        last;
    } slot_result_t;

    // DUT connections; the driven inputs are all known from time zero
    logic                            clk        = 1'b0;
    logic                            rst_n      = 1'b0;
    logic                            cfg_we     = 1'b0;
    logic                            cfg_index  = alfe_pkg::CFG_TIMER_PERIOD;
    logic [alfe_pkg::CFG_DATA_W-1:0] cfg_data   = '0;
    logic                            in_valid   = 1'b0;
    logic                            in_stall;
    logic [1:0]                      req_type   = alfe_pkg::REQ_WRITE;
    logic [7:0]                      led_number = '0;
    logic [7:0]                      green      = '0;
    logic [7:0]                      red        = '0;
    logic [7:0]                      blue       = '0;
    logic [7:0]                      brightness = '0;
    logic                            out_valid;
    logic                            out_stall  = 1'b0;
    logic [15:0]                     compare_value;
    logic                            last_slot;

    // Transactions waiting to be offered, and results still owed by the block
    led_req_t     request_queue[$];
    slot_result_t expected_slots[$];
    led_req_t     offered;

    // Encoder model state
    logic [alfe_pkg::COLOR_W-1:0] colour_mem [alfe_pkg::MAX_LEDS];
    logic [15:0]                  period_reg = 16'd89;
    logic [7:0]                   count_reg  = 8'd1;
    bit                           frame_open = 1'b0;
    int unsigned                  frame_pos  = 0;

    // Idle rates in percent, and long hold-off requests to the monitor
    int unsigned sender_idle_pct   = 7;
    int unsigned receiver_idle_pct = 49;
    int unsigned holds_asked       = 0;
    int unsigned holds_served      = 0;
    int unsigned hold_left         = 0;

    int unsigned cycle_count     = 0;
    int unsigned errors          = 0;
    int unsigned txn_accepted    = 0;
    int unsigned results_checked = 0;
    int unsigned frames_done     = 0;

    addressable_led_frame_encoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .led_number    (led_number),
        .green         (green),
        .red           (red),
        .blue          (blue),
        .brightness    (brightness),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .compare_value (compare_value),
        .last_slot     (last_slot)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Encoder model
    // ------------------------------------------------------------------

    // Zero LEDs counts as one; an 8-bit count never exceeds the store depth
    function automatic int unsigned chain_length();
        return (count_reg == 8'd0) ? 1 : int'(count_reg);
    endfunction

    // floor(c * pct / 100), exact integer
    function automatic logic [7:0] dim(logic [7:0] c, int unsigned pct);
        return 8'((int'(c) * pct) / 100);
    endfunction

    // Applies one accepted transaction to the model and queues any slot result
    function automatic void encode_request(led_req_t t);
        int unsigned  n;
        int unsigned  pct;
        int unsigned  pos_led;
        int unsigned  p1;
        int unsigned  span;
        slot_result_t res;
        logic [23:0]  word;

        n = chain_length();
        case (t.kind)
            alfe_pkg::REQ_WRITE:
            begin
                pct = (t.bright > 8'd100) ? 100 : int'(t.bright);
                pos_led = (t.led == 8'd0) ? 1 : int'(t.led);
                if (pos_led > n)
                    pos_led = n;
                colour_mem[pos_led - 1] = {dim(t.g, pct), dim(t.r, pct), dim(t.b, pct)};
            end
            alfe_pkg::REQ_START:
            begin
                frame_open = 1'b1;
                frame_pos  = 0;
            end
            alfe_pkg::REQ_SLOT:
            begin
                if (frame_open)
                begin
                    span = n * alfe_pkg::BITS_PER_LED + alfe_pkg::RESET_SLOTS;
                    res.compare = '0;
                    res.last    = 1'b0;
                    // Data slots walk the store MSB first, G then R then B
                    if (frame_pos < n * alfe_pkg::BITS_PER_LED)
                    begin
                        word = colour_mem[frame_pos / alfe_pkg::BITS_PER_LED];
                        p1   = int'(period_reg) + 1;
                        if (word[23 - (frame_pos % alfe_pkg::BITS_PER_LED)])
                            res.compare = 16'((p1 * 2) / 3);
                        else
                            res.compare = 16'(p1 / 3);
                    end
                    // A count lowered mid-frame may leave the position past the end
                    if (frame_pos + 1 >= span)
                    begin
                        res.last   = 1'b1;
                        frame_open = 1'b0;
                        frame_pos  = 0;
                    end
                    else
                        frame_pos++;
                    expected_slots.push_back(res);
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void push_req(logic [1:0] kind, logic [7:0] led, logic [7:0] g,
                                     logic [7:0] r, logic [7:0] b, logic [7:0] bright);
        led_req_t t;
        t.kind   = kind;
        t.led    = led;
        t.g      = g;
        t.r      = r;
        t.b      = b;
        t.bright = bright;
        request_queue.push_back(t);
    endfunction

    // Random payload throughout; colour writes lean towards LEDs in the chain
    // and towards the brightness clamp boundary
    function automatic void push_random(logic [1:0] kind, int unsigned n);
        led_req_t t;
        t.kind   = kind;
        t.led    = 8'($urandom);
        t.g      = 8'($urandom);
        t.r      = 8'($urandom);
        t.b      = 8'($urandom);
        t.bright = 8'($urandom);
        if (kind == alfe_pkg::REQ_WRITE)
        begin
            case ($urandom_range(9))
                0:       t.led = 8'd0;
                1:       t.led = 8'd255;
                2:       ;
                default: t.led = 8'($urandom_range(n, 1));
            endcase
            case ($urandom_range(4))
                0:       t.bright = 8'd100;
                1:       t.bright = 8'($urandom_range(255, 101));
                2:       ;
                default: t.bright = 8'($urandom_range(100, 0));
            endcase
            if ($urandom_range(7) == 0)
            begin
                t.g = {8{1'($urandom)}};
                t.r = {8{1'($urandom)}};
                t.b = {8{1'($urandom)}};
            end
        end
        request_queue.push_back(t);
    endfunction

    // Whole frames with random colours, sprinkled with ignored codes,
    // mid-frame colour writes and the odd restart
    function automatic void queue_frames(int unsigned budget);
        int unsigned n;
        int unsigned span;
        int unsigned k;
        int unsigned added;

        n = chain_length();
        span = n * alfe_pkg::BITS_PER_LED + alfe_pkg::RESET_SLOTS;
        added = 0;
        while (added < budget)
        begin
            repeat ($urandom_range((n < 4) ? n : 4, 1))
            begin
                push_random(alfe_pkg::REQ_WRITE, n);
                added++;
            end
            // Slot request between frames: normally ignored
            if ($urandom_range(3) == 0)
            begin
                push_random(alfe_pkg::REQ_SLOT, n);
                added++;
            end
            push_random(alfe_pkg::REQ_START, n);
            added++;
            k = 0;
            while (k < span)
            begin
                case ($urandom_range(99))
                    0:       push_random(REQ_SPARE, n);
                    1, 2:    push_random(alfe_pkg::REQ_WRITE, n);
                    3:
                    begin
                        if ($urandom_range(3) == 0)
                        begin
                            push_random(alfe_pkg::REQ_START, n);
                            k = 0;
                        end
                        else
                            push_random(REQ_SPARE, n);
                    end
                    default:
                    begin
                        push_random(alfe_pkg::REQ_SLOT, n);
                        k++;
                    end
                endcase
                added++;
            end
        end
    endfunction

    // Register write; the model follows at once since the block is idle
    task automatic write_register(logic idx, logic [alfe_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == alfe_pkg::CFG_TIMER_PERIOD)
            period_reg = value;
        else
            count_reg = value[7:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Sender pause: everything offered and answered, then let the
    // pipeline settle before anything else happens
    task automatic drain();
        while (request_queue.size() != 0 || in_valid || expected_slots.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: a transaction completes on in_valid && !in_stall; the next
    // one is offered only then or while the channel is empty
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : request_driver
        bit sent;
        sent = rst_n && in_valid && !in_stall;
        if (sent)
        begin
            encode_request(offered);
            txn_accepted++;
        end
        if (rst_n && (sent || !in_valid))
        begin
            if (request_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                offered = request_queue.pop_front();
                in_valid   <= 1'b1;
                req_type   <= offered.kind;
                led_number <= offered.led;
                green      <= offered.g;
                red        <= offered.r;
                blue       <= offered.b;
                brightness <= offered.bright;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor and output stall: long hold-offs take priority over the
    // random stall rate
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        slot_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_slots.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, %s=%0d last_slot=%0b",
                         $time, "actual compare_value", compare_value, last_slot);
                errors++;
            end
            else
            begin
                want = expected_slots.pop_front();
                results_checked++;
                if (compare_value !== want.compare)
                begin
                    $display("%0t: compare_value mismatch, expected %0d, actual %0d",
                             $time, want.compare, compare_value);
                    errors++;
                end
                if (last_slot !== want.last)
                begin
                    $display("%0t: last_slot mismatch, expected %0b, actual %0b",
                             $time, want.last, last_slot);
                    errors++;
                end
                if (want.last)
                    frames_done++;
            end
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (holds_served < holds_asked)
        begin
            holds_served++;
            hold_left = LONG_HOLD - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results still owed",
                     $time, cycle_count, expected_slots.size());
            $display("** addressable_led_frame_encoder_unit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : test_sequence
        int unsigned n;

        foreach (colour_mem[i])
            colour_mem[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset settings (period 89, one LED), store still clear.
        // Slot while idle and the spare code are both ignored.
        push_req(alfe_pkg::REQ_SLOT,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        push_req(REQ_SPARE,           8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        push_req(alfe_pkg::REQ_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        push_req(alfe_pkg::REQ_SLOT,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        push_req(alfe_pkg::REQ_SLOT,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        // LED zero maps to the first LED; brightness above 100 clamps
        push_req(alfe_pkg::REQ_WRITE, 8'd0,   8'd255, 8'd0,   8'd170, 8'd255);
        push_req(alfe_pkg::REQ_SLOT,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        // LED beyond the chain clamps to the last one
        push_req(alfe_pkg::REQ_WRITE, 8'd255, 8'd0,   8'd255, 8'd1,   8'd100);
        push_req(alfe_pkg::REQ_WRITE, 8'd1,   8'd255, 8'd255, 8'd255, 8'd0);
        push_req(alfe_pkg::REQ_WRITE, 8'd1,   8'd200, 8'd99,  8'd255, 8'd101);
        push_req(alfe_pkg::REQ_WRITE, 8'd1,   8'd255, 8'd128, 8'd77,  8'd99);
        push_req(alfe_pkg::REQ_SLOT,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        push_req(alfe_pkg::REQ_SLOT,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        // Restart mid-frame goes back to the first slot
        push_req(alfe_pkg::REQ_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        repeat (4) push_random(alfe_pkg::REQ_SLOT, 1);
        drain();

        // Zero LED count promoted to one, shortest period; the frame opened
        // above is still running. Long output hold-off while frames queue up.
        write_register(alfe_pkg::CFG_LED_COUNT, {8'hA5, 8'd0});
        write_register(alfe_pkg::CFG_TIMER_PERIOD, 16'd0);
        queue_frames(500);
        holds_asked++;
        drain();

        // Longest chain and period: part of a frame only
        write_register(alfe_pkg::CFG_LED_COUNT, 16'd255);
        write_register(alfe_pkg::CFG_TIMER_PERIOD, 16'hFFFF);
        n = chain_length();
        for (int i = 0; i <= 8; i++)
            push_req(alfe_pkg::REQ_WRITE, 8'(i), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'd100);
        push_random(alfe_pkg::REQ_WRITE, n);
        push_random(alfe_pkg::REQ_START, n);
        repeat (150) push_random(alfe_pkg::REQ_SLOT, n);
        drain();

        // Chain cut to three LEDs with the position already past the new end:
        // the next slot closes the frame. Idle rates swapped.
        sender_idle_pct   = 49;
        receiver_idle_pct = 7;
        write_register(alfe_pkg::CFG_LED_COUNT, 16'd3);
        write_register(alfe_pkg::CFG_TIMER_PERIOD, 16'd65534);
        push_random(alfe_pkg::REQ_SLOT, 3);
        queue_frames(500);
        holds_asked++;
        drain();

        // Back to back, no idling
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        write_register(alfe_pkg::CFG_LED_COUNT, {8'($urandom), 8'd2});
        write_register(alfe_pkg::CFG_TIMER_PERIOD, 16'($urandom));
        queue_frames(500);
        drain();

        $display("Covered %0d request transactions and %0d slot results over %0d frames,",
                 txn_accepted, results_checked, frames_done);
        $display("chains of 1, 2, 3 and 255 LEDs, periods 0 to 65535, %0d mismatches.",
                 errors);
        if (errors == 0 && expected_slots.size() == 0)
            $display("** addressable_led_frame_encoder_unit: PASSED **");
        else
            $display("** addressable_led_frame_encoder_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
hdl/alfe_pkg.sv
hdl/alfe_ram.sv
hdl/alfe_scale.sv
hdl/addressable_led_frame_encoder_unit.sv
test/tb_addressable_led_frame_encoder_unit.sv
